### hdl/trdt_pkg.sv
// Package for the TCP reorder delay tracker.
// Shared constants, status codes and controller/datapath interface structs.
// No dependencies.
`default_nettype none

package trdt_pkg;

  localparam int GAP_ENTRIES = 16;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  RETRANS_RESET  = 8'd3;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [2:0] {
    ST_NOT_IPV4  = 3'd0,
    ST_HANDSHAKE = 3'd1,
    ST_OTHER_DIR = 3'd2,
    ST_IN_ORDER  = 3'd3,
    ST_GAP_REC   = 3'd4,
    ST_GAP_FULL  = 3'd5
  } status_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // take the input item, count the frame
    logic hdr;    // handshake latches, payload length, first expected value
    logic dir;    // direction test and relative sequences
    logic cmp;    // status decision, expected update, scan setup
    logic scan;   // one step of the gap table walk
    logic fin;    // commit table updates, load result register
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic not_ipv4;
    logic walk;
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

### hdl/tcp_reorder_delay_tracker_top.sv
// TCP reorder delay tracker, top level. A non-IPv4 frame goes from the header
// step straight to the result; other frames pass the direction and compare steps,
// and a frame toward the receiver past the handshake also walks the gap table
// memory serially (a registered read, then one entry per cycle). One item at
// a time; a waiting result stalls the next item's last step. Reset clears
// counters and gap valid bits, sets latches to ones.
`default_nettype none

module tcp_reorder_delay_tracker_top #(
  parameter int GAP_ENTRIES = trdt_pkg::GAP_ENTRIES
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_we,
  input  wire  [7:0]                      cfg_data,   // retrans_threshold
  input  wire                             s_tvalid,
  output logic                            s_tready,
  // ethertype[15:0] dest_address[47:16] seq_number[79:48] syn_flag[80]
  // ack_flag[81] ip_total_length[97:82] ip_header_words[101:98]
  // tcp_header_words[105:102], zero padding above
  input  wire  [trdt_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  wire                             m_tready,
  // status[2:0] match_found[3] match_delay[35:4] retransmitted[36]
  // frame_number[68:37], zero padding above
  output logic [trdt_pkg::OUT_DATA_W-1:0] m_tdata
);

  trdt_pkg::ctrl_cmd_t cmd;
  trdt_pkg::dp_sts_t   sts;

  trdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  trdt_datapath #(
    .GAP_ENTRIES (GAP_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

  // One item in flight: no second accept right after the first
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item accepted while one is in flight");

  // Retransmission only reported with a match
  a_retrans_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[36] || m_tdata[3]))
    else $error("retransmitted without match");

  // Delay is zero without a match
  a_delay_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[3]) |-> (m_tdata[35:4] == 32'd0))
    else $error("nonzero delay without match");

  // Status stays within the defined codes
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= trdt_pkg::ST_GAP_FULL))
    else $error("status code out of range");

endmodule

`default_nettype wire

### hdl/trdt_ctrl.sv
// Controller state machine for the TCP reorder delay tracker.
// Sequences header evaluation, gap table walk and result hand-off.
// Depends on trdt_pkg.
`default_nettype none

module trdt_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  trdt_pkg::dp_sts_t    sts,
  output trdt_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_DIR,
    S_CMP,
    S_SCAN,
    S_FIN
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_HDR;
        end
        S_HDR: begin
          if (sts.not_ipv4) state <= S_FIN;
          else              state <= S_DIR;
        end
        S_DIR: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (sts.walk) state <= S_SCAN;
          else          state <= S_FIN;
        end
        S_SCAN: begin
          if (sts.scan_done) state <= S_FIN;
        end
        S_FIN: begin
          if (sts.out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold off input while in reset
  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    cmd      = '0;
    cmd.load = in_ready && in_valid;
    cmd.hdr  = (state == S_HDR);
    cmd.dir  = (state == S_DIR);
    cmd.cmp  = (state == S_CMP);
    cmd.scan = (state == S_SCAN);
    cmd.fin  = (state == S_FIN) && sts.out_free;
  end

endmodule

`default_nettype wire

### hdl/trdt_datapath.sv
// Datapath for the TCP reorder delay tracker: header registers, sequence
// arithmetic, gap table memory with serial walk, result register.
// Depends on trdt_pkg.
`default_nettype none

module trdt_datapath #(
  parameter int GAP_ENTRIES = trdt_pkg::GAP_ENTRIES
) (
  input  wire                                clk,
  input  wire                                rst,
  input  trdt_pkg::ctrl_cmd_t                cmd,
  output trdt_pkg::dp_sts_t                  sts,
  input  wire                                cfg_we,
  input  wire  [7:0]                         cfg_data,
  input  wire  [trdt_pkg::IN_DATA_W-1:0]     in_data,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [trdt_pkg::OUT_DATA_W-1:0]    out_data
);

  localparam int IW = (GAP_ENTRIES > 1) ? $clog2(GAP_ENTRIES) : 1;
  localparam int CW = $clog2(GAP_ENTRIES + 1);
  localparam logic [CW-1:0] SCAN_END = CW'(GAP_ENTRIES);

  // Latched input item
  logic [15:0] ethertype;
  logic [31:0] dest_address;
  logic [31:0] seq_number;
  logic        syn_flag;
  logic        ack_flag;
  logic [15:0] ip_total_length;
  logic [3:0]  ip_header_words;
  logic [3:0]  tcp_header_words;

  // Tracker state
  logic [7:0]  retrans_threshold;
  logic [31:0] frame_count;
  logic [31:0] receiver_initial_seq;
  logic [31:0] sender_initial_seq;
  logic [31:0] receiver_address;
  logic [31:0] expected_relative_seq;
  logic        expected_valid;
  logic [GAP_ENTRIES-1:0] gap_valid;
  logic [63:0] gap_mem [GAP_ENTRIES];

  // Per-item working registers
  logic [31:0] payload_calc;
  logic [31:0] payload_length;
  logic        toward;
  logic [31:0] rel_seq;
  logic [31:0] sender_rel_seq;
  logic        need_rec;
  logic [31:0] rec_seq;
  trdt_pkg::status_t status;

  // Walk registers
  logic [CW-1:0] scan_cnt;
  logic          rd_valid;
  logic [IW-1:0] rd_idx;
  logic [31:0]   rd_seq;
  logic [31:0]   rd_frame;
  logic          dup_found;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic          match_found;
  logic [IW-1:0] match_idx;
  logic [31:0]   match_frame;

  logic          scan_last;
  logic          rd_entry_valid;
  logic          gap_write;
  logic [31:0]   delay;
  logic          retrans;
  trdt_pkg::status_t status_final;

  assign payload_calc   = 32'(ip_total_length)
                          - ({28'd0, ip_header_words} << 2)
                          - ({28'd0, tcp_header_words} << 2);
  assign scan_last      = (scan_cnt == SCAN_END);
  assign rd_entry_valid = gap_valid[rd_idx];
  assign gap_write      = cmd.fin && need_rec && !dup_found && free_found;
  assign delay          = frame_count - match_frame;
  assign retrans        = match_found && (delay >= {24'd0, retrans_threshold});

  always_comb begin
    status_final = status;
    if (need_rec) begin
      if (dup_found || free_found) status_final = trdt_pkg::ST_GAP_REC;
      else                         status_final = trdt_pkg::ST_GAP_FULL;
    end
  end

  assign sts.not_ipv4  = (ethertype != trdt_pkg::ETHERTYPE_IPV4);
  assign sts.walk      = toward && (rel_seq[31:1] != 31'd0);
  assign sts.scan_done = scan_last;
  assign sts.out_free  = !out_valid || out_ready;

  // Input capture and per-item datapath
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ethertype        <= in_data[15:0];
      dest_address     <= in_data[47:16];
      seq_number       <= in_data[79:48];
      syn_flag         <= in_data[80];
      ack_flag         <= in_data[81];
      ip_total_length  <= in_data[97:82];
      ip_header_words  <= in_data[101:98];
      tcp_header_words <= in_data[105:102];
      status           <= trdt_pkg::ST_NOT_IPV4;
    end
    if (cmd.hdr) begin
      payload_length <= payload_calc;
    end
    if (cmd.dir) begin
      toward         <= (dest_address == receiver_address);
      rel_seq        <= seq_number - receiver_initial_seq;
      sender_rel_seq <= seq_number - sender_initial_seq;
    end
    if (cmd.cmp) begin
      rec_seq <= expected_relative_seq;
      if (!toward) begin
        status <= (sender_rel_seq[31:1] == 31'd0) ? trdt_pkg::ST_HANDSHAKE
                                                  : trdt_pkg::ST_OTHER_DIR;
      end else if (rel_seq[31:1] == 31'd0) begin
        status <= trdt_pkg::ST_HANDSHAKE;
      end else begin
        status <= trdt_pkg::ST_IN_ORDER;
      end
    end
    if (cmd.scan && !scan_last) begin
      rd_idx <= scan_cnt[IW-1:0];
    end
    if (cmd.scan && rd_valid) begin
      if (!free_found && !rd_entry_valid) free_idx <= rd_idx;
      if (!match_found && rd_entry_valid && rd_seq == rel_seq) begin
        match_idx   <= rd_idx;
        match_frame <= rd_frame;
      end
    end
  end

  // Gap table memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.scan && !scan_last) begin
      {rd_seq, rd_frame} <= gap_mem[scan_cnt[IW-1:0]];
    end
    if (gap_write) begin
      gap_mem[free_idx] <= {rec_seq, frame_count};
    end
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      retrans_threshold     <= trdt_pkg::RETRANS_RESET;
      frame_count           <= '0;
      receiver_initial_seq  <= '1;
      sender_initial_seq    <= '1;
      receiver_address      <= '1;
      expected_relative_seq <= '0;
      expected_valid        <= 1'b0;
      gap_valid             <= '0;
      need_rec              <= 1'b0;
      scan_cnt              <= '0;
      rd_valid              <= 1'b0;
      dup_found             <= 1'b0;
      free_found            <= 1'b0;
      match_found           <= 1'b0;
      out_valid             <= 1'b0;
    end else begin
      if (cfg_we) retrans_threshold <= cfg_data;

      if (cmd.load) begin
        frame_count <= frame_count + 32'd1;
        need_rec    <= 1'b0;
        match_found <= 1'b0;
        dup_found   <= 1'b0;
        free_found  <= 1'b0;
      end

      if (cmd.hdr && !sts.not_ipv4) begin
        if (syn_flag && ack_flag) begin
          receiver_initial_seq <= seq_number;
          receiver_address     <= dest_address;
        end
        if (syn_flag && !ack_flag) sender_initial_seq <= seq_number;
        // First IPv4 frame seeds the expected sequence with its payload length
        if (!expected_valid) begin
          expected_valid        <= 1'b1;
          expected_relative_seq <= payload_calc;
        end
      end

      if (cmd.cmp) begin
        scan_cnt <= '0;
        rd_valid <= 1'b0;
        if (sts.walk) begin
          need_rec              <= (rel_seq < expected_relative_seq);
          expected_relative_seq <= rel_seq + payload_length;
        end
      end

      if (cmd.scan) begin
        rd_valid <= !scan_last;
        if (!scan_last) scan_cnt <= scan_cnt + CW'(1);
        if (rd_valid) begin
          if (rd_entry_valid && rd_seq == rec_seq) dup_found <= 1'b1;
          if (!rd_entry_valid) free_found <= 1'b1;
          if (rd_entry_valid && rd_seq == rel_seq) match_found <= 1'b1;
        end
      end

      if (cmd.fin) begin
        if (gap_write) gap_valid[free_idx] <= 1'b1;
        if (match_found) gap_valid[match_idx] <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_data <= {3'd0,
                   frame_count,
                   retrans,
                   match_found ? delay : 32'd0,
                   match_found,
                   status_final};
    end
  end

endmodule

`default_nettype wire

### bench/tcp_reorder_delay_tracker_top_tb.sv
// Self-checking bench for tcp_reorder_delay_tracker_top: directed TCP frames, then random
// flows with reordered, repeated and noisy segments under bursty input and output stalls.
// Depends on trdt_pkg and the top level; a local tracker model computes every verdict.
module tcp_reorder_delay_tracker_top_tb;

  typedef struct packed {
    logic [3:0]  doff;
    logic [3:0]  ihl;
    logic [15:0] tot_len;
    logic        ack;
    logic        syn;
    logic [31:0] seq;
    logic [31:0] dest;
    logic [15:0] ethertype;
  } frame_t;

  typedef struct packed {
    logic [31:0]       frame_number;
    logic              retransmitted;
    logic [31:0]       match_delay;
    logic              match_found;
    trdt_pkg::status_t status;
  } verdict_t;

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [7:0]                      cfg_data = 8'd0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [trdt_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [trdt_pkg::OUT_DATA_W-1:0] m_tdata;

  tcp_reorder_delay_tracker_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  frame_t   frame_q[$];
  verdict_t verdict_q[$];
  int       queued_frames = 0;
  int       results_seen = 0;
  int       fault_count = 0;

  // Tracker state mirrored from the block
  logic [7:0]  trk_threshold = trdt_pkg::RETRANS_RESET;
  logic [31:0] trk_frames = '0;
  logic [31:0] trk_rcv_isn = '1;
  logic [31:0] trk_snd_isn = '1;
  logic [31:0] trk_rcv_addr = '1;
  logic [31:0] trk_next_rel = '0;
  logic        trk_next_set = 1'b0;
  logic [31:0] gap_seq_tbl [trdt_pkg::GAP_ENTRIES];
  logic [31:0] gap_frm_tbl [trdt_pkg::GAP_ENTRIES];
  logic        gap_vld_tbl [trdt_pkg::GAP_ENTRIES];

  initial begin
    for (int i = 0; i < trdt_pkg::GAP_ENTRIES; i++) begin
      gap_vld_tbl[i] = 1'b0;
      gap_seq_tbl[i] = '0;
      gap_frm_tbl[i] = '0;
    end
  end

  function automatic verdict_t track_frame(input frame_t f);
    verdict_t    v;
    logic [31:0] plen, rel, srel, tot, hdr;
    bit          pending, placed, hit;
    v = '0;
    trk_frames = trk_frames + 32'd1;
    v.frame_number = trk_frames;
    v.status = trdt_pkg::ST_NOT_IPV4;
    if (f.ethertype == trdt_pkg::ETHERTYPE_IPV4) begin
      if (f.syn && f.ack) begin
        trk_rcv_isn = f.seq;
        trk_rcv_addr = f.dest;
      end
      if (f.syn && !f.ack)
        trk_snd_isn = f.seq;
      tot = {16'd0, f.tot_len};
      hdr = ({28'd0, f.ihl} + {28'd0, f.doff}) * 32'd4;
      plen = tot - hdr;
      if (!trk_next_set) begin
        trk_next_rel = plen;
        trk_next_set = 1'b1;
      end
      if (f.dest != trk_rcv_addr) begin
        srel = f.seq - trk_snd_isn;
        v.status = (srel == 32'd0 || srel == 32'd1) ? trdt_pkg::ST_HANDSHAKE
                                                    : trdt_pkg::ST_OTHER_DIR;
      end else begin
        rel = f.seq - trk_rcv_isn;
        if (rel == 32'd0 || rel == 32'd1) begin
          v.status = trdt_pkg::ST_HANDSHAKE;
        end else begin
          if (rel < trk_next_rel) begin
            pending = 1'b0;
            for (int i = 0; i < trdt_pkg::GAP_ENTRIES; i++)
              if (gap_vld_tbl[i] && gap_seq_tbl[i] == trk_next_rel) pending = 1'b1;
            placed = pending;
            for (int i = 0; i < trdt_pkg::GAP_ENTRIES; i++) begin
              if (!placed && !gap_vld_tbl[i]) begin
                gap_vld_tbl[i] = 1'b1;
                gap_seq_tbl[i] = trk_next_rel;
                gap_frm_tbl[i] = trk_frames;
                placed = 1'b1;
              end
            end
            v.status = placed ? trdt_pkg::ST_GAP_REC : trdt_pkg::ST_GAP_FULL;
          end else begin
            v.status = trdt_pkg::ST_IN_ORDER;
          end
          trk_next_rel = rel + plen;
          // free the lowest valid slot holding this sequence
          hit = 1'b0;
          for (int i = 0; i < trdt_pkg::GAP_ENTRIES; i++) begin
            if (!hit && gap_vld_tbl[i] && gap_seq_tbl[i] == rel) begin
              hit = 1'b1;
              v.match_found = 1'b1;
              v.match_delay = trk_frames - gap_frm_tbl[i];
              v.retransmitted = (v.match_delay >= {24'd0, trk_threshold});
              gap_vld_tbl[i] = 1'b0;
            end
          end
        end
      end
    end
    return v;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // Driver: bursts of items with random gaps; hold the item while stalled
  frame_t cur_frame;
  int     burst_left = 0;
  int     idle_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        verdict_q.push_back(track_frame(cur_frame));
      if (s_tvalid && !s_tready) begin
        // hold
      end else if (idle_left > 0) begin
        idle_left--;
        s_tvalid <= 1'b0;
      end else if (frame_q.size() != 0) begin
        cur_frame = frame_q.pop_front();
        s_tdata <= {{(trdt_pkg::IN_DATA_W - $bits(frame_t)){1'b0}}, cur_frame};
        s_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, with one long hold-off once traffic is flowing
  int  rx_mode = 0;
  int  rx_mode_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && results_seen >= 300) begin
      hold_done = 1'b1;
      hold_left = 400;
      m_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(32, 256);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= ~m_tready;
      endcase
    end
  end

  // Monitor: compare each result with the oldest pending verdict
  verdict_t got, want;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(verdict_t)-1:0];
      results_seen++;
      if (verdict_q.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected result %0d: status %0d frame %0d", results_seen, got.status,
                   got.frame_number);
      end else begin
        want = verdict_q.pop_front();
        if (got.status !== want.status || got.match_found !== want.match_found ||
            got.match_delay !== want.match_delay ||
            got.retransmitted !== want.retransmitted ||
            got.frame_number !== want.frame_number) begin
          fault_count++;
          if (fault_count <= 10)
            $display({"mismatch at result %0d: want st %0d mf %0b dly %0d rt %0b fr %0d,",
                      " got st %0d mf %0b dly %0d rt %0b fr %0d"},
                     results_seen, want.status, want.match_found, want.match_delay,
                     want.retransmitted, want.frame_number, got.status, got.match_found,
                     got.match_delay, got.retransmitted, got.frame_number);
        end
      end
    end
  end

  task automatic push_frame(input logic [15:0] eth, input logic [31:0] dest, seq,
                            input logic syn, ack, input logic [15:0] tot,
                            input logic [3:0] ihl, doff);
    frame_t f;
    f.ethertype = eth;
    f.dest = dest;
    f.seq = seq;
    f.syn = syn;
    f.ack = ack;
    f.tot_len = tot;
    f.ihl = ihl;
    f.doff = doff;
    frame_q.push_back(f);
    queued_frames++;
  endtask

  // Data segment toward dest at a relative sequence; payload length len
  task automatic push_seg(input logic [31:0] dest, isn, input int rel, len);
    int ihl, doff;
    ihl = 5;
    doff = 5;
    if ($urandom_range(0, 5) == 0) begin
      ihl = $urandom_range(5, 15);
      doff = $urandom_range(5, 15);
    end
    push_frame(trdt_pkg::ETHERTYPE_IPV4, dest, isn + 32'(rel), 1'b0, 1'b1,
               16'(4 * (ihl + doff) + len), 4'(ihl), 4'(doff));
  endtask

  task automatic push_noise(input logic [31:0] addr, other);
    logic [15:0] eth;
    logic [31:0] dest;
    int          pick;
    eth = ($urandom_range(0, 2) == 0) ? 16'($urandom) : trdt_pkg::ETHERTYPE_IPV4;
    pick = $urandom_range(0, 3);
    dest = (pick == 0) ? addr : (pick == 1) ? other : (pick == 2) ? 32'hFFFF_FFFF : $urandom;
    push_frame(eth, dest, $urandom, ($urandom_range(0, 7) == 0), 1'($urandom_range(0, 1)),
               16'($urandom), 4'($urandom), 4'($urandom));
  endtask

  task automatic gen_flow();
    logic [31:0] addr, other, isn, sisn;
    int          rels [0:24];
    int          lens [0:24];
    int          ord [0:24];
    int          k, mode, a, b, t;
    addr = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom;
    other = $urandom;
    if (other == addr) other = ~addr;
    isn = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000) : $urandom;
    sisn = $urandom;
    if ($urandom_range(0, 3) != 0)
      push_frame(trdt_pkg::ETHERTYPE_IPV4, addr, sisn, 1'b1, 1'b0, 16'd40, 4'd5, 4'd5);
    push_frame(trdt_pkg::ETHERTYPE_IPV4, addr, isn, 1'b1, 1'b1, 16'd40, 4'd5, 4'd5);
    mode = $urandom_range(0, 4);
    k = (mode == 3) ? $urandom_range(14, 20) : $urandom_range(4, 12);
    rels[0] = $urandom_range(2, 60);
    for (int i = 0; i < k; i++) begin
      lens[i] = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 1460);
      rels[i+1] = rels[i] + lens[i];
      ord[i] = i;
    end
    lens[k] = $urandom_range(0, 1460);
    case (mode)
      1: begin
        for (int i = 0; i < k - 1; i++) begin
          if ($urandom_range(0, 2) == 0) begin
            t = ord[i]; ord[i] = ord[i+1]; ord[i+1] = t;
            i++;
          end
        end
      end
      2: begin
        // move one segment one or more places later
        a = $urandom_range(0, k - 2);
        b = $urandom_range(a + 1, k - 1);
        t = ord[a];
        for (int i = a; i < b; i++) ord[i] = ord[i+1];
        ord[b] = t;
      end
      3: begin
        for (int i = 0; i < k; i++) ord[i] = k - 1 - i;
      end
      4: begin
        for (int i = k - 1; i > 0; i--) begin
          a = $urandom_range(0, i);
          t = ord[i]; ord[i] = ord[a]; ord[a] = t;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < k; i++) begin
      push_seg(addr, isn, rels[ord[i]], lens[ord[i]]);
      if ($urandom_range(0, 11) == 0)
        push_seg(addr, isn, rels[ord[i]], lens[ord[i]]);
      if ($urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 1) == 0)
          push_frame(trdt_pkg::ETHERTYPE_IPV4, other, sisn + $urandom_range(2, 5000), 1'b0,
                     1'b1, 16'd80, 4'd5, 4'd5);
        else
          push_frame(16'h86DD, addr, isn + 32'(rels[i]), 1'b0, 1'b1, 16'd80, 4'd5, 4'd5);
      end
    end
    // sweep upward to fill the gaps a descending run leaves
    if (mode == 3)
      for (int i = 1; i <= k; i++) push_seg(addr, isn, rels[i], lens[i]);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (frame_q.size() != 0 || s_tvalid || verdict_q.size() != 0);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [7:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    trk_threshold = value;
  endtask

  logic [7:0] phase_thr [6];
  int         phase_end;

  initial begin
    phase_thr[0] = 8'd0;
    phase_thr[1] = 8'd255;
    phase_thr[2] = 8'd1;
    phase_thr[3] = 8'($urandom_range(2, 254));
    phase_thr[4] = 8'd2;
    phase_thr[5] = trdt_pkg::RETRANS_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, unset receiver, handshakes, gaps, matches, repeats
    push_frame(16'h0000, 32'h0, 32'h0, 1'b0, 1'b0, 16'h0, 4'h0, 4'h0);
    push_frame(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF, 4'hF, 4'hF);
    push_frame(trdt_pkg::ETHERTYPE_IPV4, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b1, 16'h0, 4'hF,
               4'hF);
    push_frame(trdt_pkg::ETHERTYPE_IPV4, 32'hFFFF_FFFF, 32'd100, 1'b0, 1'b1, 16'hFFFF, 4'd5,
               4'd5);
    push_frame(trdt_pkg::ETHERTYPE_IPV4, 32'h0A00_0001, 32'hFFFF_FFFF, 1'b0, 1'b1, 16'd40,
               4'd5, 4'd5);
    push_frame(trdt_pkg::ETHERTYPE_IPV4, 32'h0A00_0001, 32'd5, 1'b0, 1'b1, 16'd40, 4'd5,
               4'd5);
    push_frame(trdt_pkg::ETHERTYPE_IPV4, 32'h0A00_0001, 32'h1000, 1'b1, 1'b0, 16'd40, 4'd5,
               4'd5);
    push_frame(trdt_pkg::ETHERTYPE_IPV4, 32'hC0A8_0001, 32'hFFFF_FFF0, 1'b1, 1'b1, 16'd40,
               4'd5, 4'd5);
    push_seg(32'hC0A8_0001, 32'hFFFF_FFF0, 2, 10);
    push_seg(32'hC0A8_0001, 32'hFFFF_FFF0, 22, 10);
    push_seg(32'hC0A8_0001, 32'hFFFF_FFF0, 12, 10);
    push_seg(32'hC0A8_0001, 32'hFFFF_FFF0, 32, 10);
    push_seg(32'hC0A8_0001, 32'hFFFF_FFF0, 42, 10);
    push_seg(32'hC0A8_0001, 32'hFFFF_FFF0, 62, 10);
    push_seg(32'hC0A8_0001, 32'hFFFF_FFF0, 52, 10);
    push_seg(32'hC0A8_0001, 32'hFFFF_FFF0, 62, 10);
    push_seg(32'hC0A8_0001, 32'hFFFF_FFF0, 52, 10);
    push_frame(trdt_pkg::ETHERTYPE_IPV4, 32'h0A00_0001, 32'h2000, 1'b0, 1'b1, 16'd40, 4'd5,
               4'd5);
    push_frame(16'h0806, 32'hC0A8_0001, 32'h0, 1'b0, 1'b0, 16'd28, 4'd0, 4'd0);
    push_seg(32'hC0A8_0001, 32'hFFFF_FFF0, 72, 10);
    push_seg(32'hC0A8_0001, 32'hFFFF_FFF0, 82, 0);
    push_seg(32'hC0A8_0001, 32'hFFFF_FFF0, 82, 10);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      write_threshold(phase_thr[p]);
      phase_end = queued_frames + 155;
      while (queued_frames < phase_end) begin
        if ($urandom_range(0, 4) == 0)
          push_noise(trk_rcv_addr, $urandom);
        else
          gen_flow();
      end
      wait_idle();
    end

    if (fault_count == 0 && verdict_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

### files.f
hdl/trdt_pkg.sv
hdl/trdt_ctrl.sv
hdl/trdt_datapath.sv
hdl/tcp_reorder_delay_tracker_top.sv
bench/tcp_reorder_delay_tracker_top_tb.sv
